// ===== rtl/core/u16u8_pkg.sv =====
// Shared types, constants and the code point encoder of the UTF-16 to UTF-8 encoder.
package u16u8_pkg;

	localparam int COUNT_BITS = 24;
	localparam int CU_W = 16;
	localparam int CFG_W = 24;
	localparam int TOTAL_W = 24;
	localparam int JOB_BYTES = 6;
	localparam int NB_W = $clog2(JOB_BYTES + 1);
	localparam int IDX_W = $clog2(JOB_BYTES);
	localparam int SUM_W = ((COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W) + 1;
	localparam logic [SUM_W-1:0] COUNT_MAX = (SUM_W'(1) << COUNT_BITS) - SUM_W'(1);
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);

	localparam logic [0:0] REG_WRITE_ENABLE = 1'd0;
	localparam logic [0:0] REG_OUT_CAPACITY = 1'd1;

	localparam logic [CU_W-1:0] HIGH_FIRST = 16'hD800;
	localparam logic [CU_W-1:0] HIGH_LAST = 16'hDBFF;
	localparam logic [CU_W-1:0] LOW_FIRST = 16'hDC00;
	localparam logic [CU_W-1:0] LOW_LAST = 16'hDFFF;
	localparam logic [20:0] SUPP_BASE = 21'h10000;

	typedef struct packed {
		logic [3:0][7:0] b;
		logic [2:0] n;
	} enc_t;

	typedef struct packed {
		logic [JOB_BYTES-1:0][7:0] bytes;
		logic [NB_W-1:0] nbytes;
		logic last;
		logic [TOTAL_W-1:0] total;
		logic ovf;
	} job_t;

	function automatic enc_t encode_point(logic [20:0] cp);
		enc_t e;
		e.b = '0;
		if (cp < 21'h80) begin
			e.b[0] = cp[7:0];
			e.n = 3'd1;
		end else if (cp < 21'h800) begin
			e.b[0] = {3'b110, cp[10:6]};
			e.b[1] = {2'b10, cp[5:0]};
			e.n = 3'd2;
		end else if (cp < SUPP_BASE) begin
			e.b[0] = {4'b1110, cp[15:12]};
			e.b[1] = {2'b10, cp[11:6]};
			e.b[2] = {2'b10, cp[5:0]};
			e.n = 3'd3;
		end else begin
			e.b[0] = {5'b11110, cp[20:18]};
			e.b[1] = {2'b10, cp[17:12]};
			e.b[2] = {2'b10, cp[11:6]};
			e.b[3] = {2'b10, cp[5:0]};
			e.n = 3'd4;
		end
		return e;
	endfunction

endpackage

// ===== rtl/core/u16u8_front.sv =====
// Front end: takes code units, pairs surrogates, counts bytes, queues up to one job each.
module u16u8_front (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [u16u8_pkg::CU_W-1:0] s_tdata,
	input  logic s_tlast,
	input  logic cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [u16u8_pkg::CFG_W-1:0] cfg_data,
	input  logic full,
	output logic push,
	output u16u8_pkg::job_t job
);
	import u16u8_pkg::*;

	logic we_q;
	logic [CFG_W-1:0] cap_q;
	logic held_q;
	logic [9:0] held_bits_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic failed_q;

	logic accept;
	logic is_high, is_low, pair;
	logic pres_a, pres_b;
	logic [20:0] cp_a;
	enc_t enc_a, enc_b;
	logic [2:0] na, nb, na_e, nb_e, na_c, nb_c;
	logic [SUM_W-1:0] cnt_ext, cap_ext, sum_a, sum_ab, sum_new;
	logic fail_a, fail_b, f1, f2;
	logic cnt_a, cnt_b;
	logic [COUNT_BITS-1:0] cnt_next;
	logic [2:0] bidx;

	assign s_tready = !full;
	assign accept = s_tvalid && s_tready;

	assign is_high = (s_tdata >= HIGH_FIRST) && (s_tdata <= HIGH_LAST);
	assign is_low = (s_tdata >= LOW_FIRST) && (s_tdata <= LOW_LAST);
	assign pair = held_q && is_low;
	assign pres_a = held_q;
	assign pres_b = !pair && !(is_high && !s_tlast);
	assign cp_a = pair ? (SUPP_BASE + {1'b0, held_bits_q, s_tdata[9:0]})
		: {5'b0, HIGH_FIRST[15:10], held_bits_q};
	assign enc_a = encode_point(cp_a);
	assign enc_b = encode_point({5'b0, s_tdata});
	assign na = pres_a ? enc_a.n : 3'd0;
	assign nb = pres_b ? enc_b.n : 3'd0;

	assign cnt_ext = SUM_W'(cnt_q);
	assign cap_ext = SUM_W'(cap_q);
	assign sum_a = cnt_ext + SUM_W'(na);
	assign sum_ab = cnt_ext + SUM_W'(na) + SUM_W'(nb);

	assign fail_a = pres_a && we_q && !failed_q && (sum_a > cap_ext);
	assign f1 = failed_q || fail_a;
	assign fail_b = pres_b && we_q && !f1 && (sum_ab > cap_ext);
	assign f2 = f1 || fail_b;
	assign cnt_a = pres_a && !f1;
	assign cnt_b = pres_b && !f2;
	assign na_c = cnt_a ? na : 3'd0;
	assign nb_c = cnt_b ? nb : 3'd0;
	assign na_e = we_q ? na_c : 3'd0;
	assign nb_e = we_q ? nb_c : 3'd0;
	assign sum_new = cnt_ext + SUM_W'(na_c) + SUM_W'(nb_c);
	assign cnt_next = (sum_new > COUNT_MAX) ? COUNT_MAX[COUNT_BITS-1:0]
		: sum_new[COUNT_BITS-1:0];

	always_comb begin
		bidx = '0;
		job.bytes = '0;
		for (int i = 0; i < JOB_BYTES; i++) begin
			bidx = 3'(i) - na_e;
			if (3'(i) < na_e) begin
				job.bytes[i] = enc_a.b[2'(i)];
			end else if (bidx < 3'd4) begin
				job.bytes[i] = enc_b.b[bidx[1:0]];
			end
		end
		job.nbytes = NB_W'(na_e) + NB_W'(nb_e);
		job.last = s_tlast;
		job.total = (s_tlast && !f2) ? TOTAL_W'(cnt_next) : '0;
		job.ovf = f2;
	end

	assign push = accept && ((job.nbytes != '0) || s_tlast);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			we_q <= 1'b1;
			cap_q <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WRITE_ENABLE: we_q <= cfg_data[0];
				REG_OUT_CAPACITY: cap_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 1'b0;
			held_bits_q <= '0;
			cnt_q <= '0;
			failed_q <= 1'b0;
		end else if (accept) begin
			if (s_tlast) begin
				held_q <= 1'b0;
				held_bits_q <= '0;
				cnt_q <= '0;
				failed_q <= 1'b0;
			end else begin
				held_q <= !pair && is_high;
				held_bits_q <= s_tdata[9:0];
				cnt_q <= cnt_next;
				failed_q <= f2;
			end
		end
	end

endmodule

// ===== rtl/core/u16u8_fifo.sv =====
// Short job queue between the front end and the byte serializer.
module u16u8_fifo (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  u16u8_pkg::job_t wdata,
	output logic full,
	input  logic pop,
	output u16u8_pkg::job_t rdata,
	output logic empty
);
	import u16u8_pkg::*;

	job_t mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0] count_q;

	assign full = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/u16u8_back.sv =====
// Back end: serializes queued jobs into output words, one byte per cycle while m_tready allows.
module u16u8_back (
	input  logic clk,
	input  logic arst_n,
	input  u16u8_pkg::job_t head,
	input  logic empty,
	output logic pop,
	output logic m_tvalid,
	input  logic m_tready,
	output logic [31:0] m_tdata,
	output logic [2:0] m_tuser,
	output logic m_tlast
);
	import u16u8_pkg::*;

	logic valid_q;
	logic [IDX_W-1:0] idx_q;
	logic [7:0] byte_q;
	logic [TOTAL_W-1:0] total_q;
	logic bv_q, se_q, ovf_q, rl_q;
	logic load, fin, none;

	assign none = (head.nbytes == '0);
	assign fin = none || (NB_W'(idx_q) == head.nbytes - 1'b1);
	assign load = !empty && (!valid_q || m_tready);
	assign pop = load && fin;

	assign m_tvalid = valid_q;
	assign m_tdata = {total_q, byte_q};
	assign m_tuser = {ovf_q, se_q, bv_q};
	assign m_tlast = rl_q;

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= none ? 8'd0 : head.bytes[idx_q];
			bv_q <= !none;
			rl_q <= fin;
			se_q <= fin && head.last;
			total_q <= fin ? head.total : '0;
			ovf_q <= head.ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q <= fin ? '0 : idx_q + 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/utf16_to_utf8_encoder.sv =====
// Top level of the UTF-16 to UTF-8 encoder.
// The block takes one UTF-16 code unit per cycle whenever its four-entry job queue has room,
// and gives one output word per cycle while m_tready allows; a unit causes zero to six words,
// none for a held high surrogate. The sustained rate is set by the byte serializer at the
// output. A unit's bytes are written into the job queue and then into the output register.
// Surrogate pairing, capacity checking and byte counting are done in the cycle a unit is
// accepted; s_tlast ends the string, and the word that closes it carries the total, which
// reads zero after an overflow.
module utf16_to_utf8_encoder (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [15:0] s_tdata, // code_unit
	input  logic s_tlast,
	output logic m_tvalid,
	input  logic m_tready,
	output logic [31:0] m_tdata, // out_byte, total_bytes
	output logic [2:0] m_tuser, // byte_valid, string_end, overflow
	output logic m_tlast,
	input  logic cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [23:0] cfg_data
);
	import u16u8_pkg::*;

	job_t job, head;
	logic push, pop, full, empty;

	u16u8_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.full(full),
		.push(push),
		.job(job)
	);

	u16u8_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata(job),
		.full(full),
		.pop(pop),
		.rdata(head),
		.empty(empty)
	);

	u16u8_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.empty(empty),
		.pop(pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("job queued while the queue is full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("job taken from an empty queue");
	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tuser[1] && m_tlast)
		else $error("word without a byte does not close the string");
	a_total_place: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[31:8] != 24'd0) |-> m_tuser[1] && !m_tuser[2])
		else $error("total reported away from string end or after overflow");
`endif

endmodule
